>>> hdl/pre_pkg.sv
// pre_pkg: shared types, constants and divide-by-constant helpers for the
// plural rule evaluator. No dependencies.
package pre_pkg;

   localparam int MAX_TERMS  = 11;
   localparam int TERM_W     = 4;
   localparam int WORD_BYTES = 32;
   localparam int LEN_W      = 6;
   localparam int CNT_W      = 32;
   localparam int LEAD_W     = 10;
   localparam int FORM_W     = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // opcode fields
   localparam logic [2:0] CMP_EQ      = 3'd1;
   localparam logic [2:0] CMP_LT      = 3'd2;
   localparam logic [2:0] CMP_LE      = 3'd3;
   localparam logic [2:0] CMP_BETWEEN = 3'd4;
   localparam int OP_NOT_BIT   = 3;
   localparam int OP_MOD10_BIT = 4;
   localparam int OP_MOD100_BIT = 5;
   localparam int OP_LEAD_BIT  = 6;
   localparam int OP_LMASK_BIT = 7;

   // connector bytes
   localparam logic [7:0] CON_AND = 8'hFD;
   localparam logic [7:0] CON_OR  = 8'hFE;
   localparam logic [7:0] CON_NEW = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RULE_LENGTH = 3'd0,
      CSR_RULE_WORD_0 = 3'd1,
      CSR_RULE_WORD_1 = 3'd2,
      CSR_RULE_WORD_2 = 3'd3,
      CSR_RULE_WORD_3 = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      DEC_IDLE,
      DEC_START,
      DEC_OP,
      DEC_R1,
      DEC_R2,
      DEC_CON
   } dec_state_type;

   // decoded rule program, one slot per term
   typedef struct packed {
      logic [MAX_TERMS-1:0][7:0]        op;
      logic [MAX_TERMS-1:0][7:0]        r1;
      logic [MAX_TERMS-1:0][7:0]        r2;
      logic [MAX_TERMS-1:0][TERM_W-1:0] gid;
      logic [MAX_TERMS-1:0][TERM_W-1:0] rid;
      logic [TERM_W-1:0]                term_count;
      logic [TERM_W-1:0]                rule_count;
      logic                             valid;
      logic                             empty;
   } prog_type;

   // reduced views of one count
   typedef struct packed {
      logic [CNT_W-1:0]  n;
      logic [6:0]        r100;
      logic [3:0]        r10;
      logic [LEAD_W-1:0] lead;
      logic              nocnt;
   } red_type;

   // floor(x / 1000) by reciprocal multiply, exact for 32-bit x
   function automatic logic [CNT_W-1:0] div1000(input logic [CNT_W-1:0] x);
      logic [63:0] p;
      p = 64'(x) * 64'd274877907;
      return CNT_W'(p >> 38);
   endfunction

   // floor(x / 100) by reciprocal multiply, exact for 32-bit x
   function automatic logic [CNT_W-1:0] div100(input logic [CNT_W-1:0] x);
      logic [63:0] p;
      p = 64'(x) * 64'd1374389535;
      return CNT_W'(p >> 37);
   endfunction

   // one step of stripping a thousands group
   function automatic logic [CNT_W-1:0] lead_step(input logic [CNT_W-1:0] x);
      return (x >= CNT_W'(1000)) ? div1000(x) : x;
   endfunction

   // x mod 10 for x below 100
   function automatic logic [3:0] mod10_small(input logic [6:0] x);
      logic [17:0] p;
      logic [6:0]  q;
      p = 18'(x) * 18'd205;
      q = 7'(p >> 11);
      return 4'(x - 7'(q * 7'd10));
   endfunction

endpackage

>>> hdl/pre_decoder.sv
// pre_decoder: walks the rule bytes one per cycle after a register write,
// checks the program and builds the per-term table. Uses pre_pkg.
module pre_decoder #(
   parameter int RULE_BYTES = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic [pre_pkg::LEN_W-1:0]                   rule_length,
   input  logic [pre_pkg::WORD_BYTES-1:0][7:0]         rule_bytes,
   output logic                                        busy,
   output pre_pkg::prog_type                           prog
);

   localparam int LEN_CAP = (RULE_BYTES < pre_pkg::WORD_BYTES) ?
                            RULE_BYTES : pre_pkg::WORD_BYTES;

   // empty program after reset: valid, no terms
   localparam pre_pkg::prog_type PROG_RESET = '{valid: 1'b1, empty: 1'b1, default: '0};

   pre_pkg::dec_state_type          state_ff, state_in;
   pre_pkg::prog_type               prog_ff, prog_in;
   logic [pre_pkg::LEN_W-1:0]       pos_ff, pos_in;
   logic [pre_pkg::TERM_W-1:0]      term_ff, term_in;
   logic [pre_pkg::TERM_W-1:0]      gid_ff, gid_in;
   logic [pre_pkg::TERM_W-1:0]      rid_ff, rid_in;
   logic [pre_pkg::LEN_W-1:0]       len_eff;
   logic [pre_pkg::LEN_W-1:0]       pos_next;
   logic [7:0]                      cur_byte;
   logic                            last;
   logic                            op_bad;
   logic                            between;
   logic                            con_ok;

   // saturated length and byte fetch
   assign len_eff  = (rule_length > pre_pkg::LEN_W'(LEN_CAP)) ?
                     pre_pkg::LEN_W'(LEN_CAP) : rule_length;
   assign cur_byte = rule_bytes[pos_ff[pre_pkg::LEN_W-2:0]];
   assign pos_next = pos_ff + 1'b1;
   assign last     = (pos_next >= len_eff);
   assign op_bad   = cur_byte[pre_pkg::OP_LMASK_BIT] || last || (cur_byte[2:0] == 3'd0);
   assign between  = (prog_ff.op[term_ff][2:0] == pre_pkg::CMP_BETWEEN);
   assign con_ok   = (cur_byte == pre_pkg::CON_AND) || (cur_byte == pre_pkg::CON_OR) ||
                     (cur_byte == pre_pkg::CON_NEW);

   // next state
   always_comb begin
      state_in = state_ff;
      if (start) begin
         state_in = pre_pkg::DEC_START;
      end else begin
         unique case (state_ff)
            pre_pkg::DEC_IDLE:  state_in = pre_pkg::DEC_IDLE;
            pre_pkg::DEC_START: state_in = (len_eff == '0) ? pre_pkg::DEC_IDLE : pre_pkg::DEC_OP;
            pre_pkg::DEC_OP:    state_in = op_bad ? pre_pkg::DEC_IDLE : pre_pkg::DEC_R1;
            pre_pkg::DEC_R1: begin
               if (last) state_in = pre_pkg::DEC_IDLE;
               else if (between) state_in = pre_pkg::DEC_R2;
               else state_in = pre_pkg::DEC_CON;
            end
            pre_pkg::DEC_R2:    state_in = last ? pre_pkg::DEC_IDLE : pre_pkg::DEC_CON;
            pre_pkg::DEC_CON:   state_in = (!con_ok || last) ? pre_pkg::DEC_IDLE : pre_pkg::DEC_OP;
            default:            state_in = pre_pkg::DEC_IDLE;
         endcase
      end
   end

   // table and walk registers
   always_comb begin
      prog_in = prog_ff;
      pos_in  = pos_ff;
      term_in = term_ff;
      gid_in  = gid_ff;
      rid_in  = rid_ff;
      unique case (state_ff)
         pre_pkg::DEC_START: begin
            pos_in             = '0;
            term_in            = '0;
            gid_in             = '0;
            rid_in             = '0;
            prog_in.empty      = (len_eff == '0);
            prog_in.valid      = (len_eff == '0);
            prog_in.term_count = '0;
            prog_in.rule_count = '0;
         end
         pre_pkg::DEC_OP: begin
            prog_in.op[term_ff] = cur_byte;
            pos_in              = pos_next;
         end
         pre_pkg::DEC_R1: begin
            prog_in.r1[term_ff]  = cur_byte;
            prog_in.r2[term_ff]  = '0;
            prog_in.gid[term_ff] = gid_ff;
            prog_in.rid[term_ff] = rid_ff;
            pos_in               = pos_next;
            if (last && !between) begin
               prog_in.valid      = 1'b1;
               prog_in.term_count = term_ff + 1'b1;
               prog_in.rule_count = rid_ff + 1'b1;
            end
         end
         pre_pkg::DEC_R2: begin
            prog_in.r2[term_ff] = cur_byte;
            pos_in              = pos_next;
            if (last) begin
               prog_in.valid      = 1'b1;
               prog_in.term_count = term_ff + 1'b1;
               prog_in.rule_count = rid_ff + 1'b1;
            end
         end
         pre_pkg::DEC_CON: begin
            pos_in = pos_next;
            if (con_ok && !last) begin
               term_in = term_ff + 1'b1;
               if (cur_byte != pre_pkg::CON_AND) gid_in = gid_ff + 1'b1;
               if (cur_byte == pre_pkg::CON_NEW) rid_in = rid_ff + 1'b1;
            end
         end
         default: begin
            prog_in = prog_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pre_pkg::DEC_IDLE;
         prog_ff  <= PROG_RESET;
         pos_ff   <= '0;
         term_ff  <= '0;
         gid_ff   <= '0;
         rid_ff   <= '0;
      end else begin
         state_ff <= state_in;
         prog_ff  <= prog_in;
         pos_ff   <= pos_in;
         term_ff  <= term_in;
         gid_ff   <= gid_in;
         rid_ff   <= rid_in;
      end
   end

   assign busy = (state_ff != pre_pkg::DEC_IDLE);
   assign prog = prog_ff;

endmodule

>>> hdl/pre_reduce.sv
// pre_reduce: three pipeline stages that form count mod 100, mod 10 and the
// leading thousands group. Uses pre_pkg.
module pre_reduce #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [pre_pkg::CNT_W-1:0] in_count,
   output logic                      out_valid,
   input  logic                      out_ready,
   output pre_pkg::red_type          out_red
);

   localparam logic [pre_pkg::CNT_W-1:0] CNT_MASK = (COUNT_WIDTH >= pre_pkg::CNT_W) ? '1 :
      pre_pkg::CNT_W'((64'd1 << COUNT_WIDTH) - 64'd1);
   localparam logic NOCNT_OK = (COUNT_WIDTH <= pre_pkg::CNT_W);

   logic                      v1_ff, v2_ff, v3_ff;
   logic                      rdy1, rdy2, rdy3;
   logic [pre_pkg::CNT_W-1:0] n_in;
   logic [pre_pkg::CNT_W-1:0] n1_ff, n2_ff, n3_ff;
   logic                      nc1_ff, nc2_ff, nc3_ff;
   logic [pre_pkg::CNT_W-1:0] q100_ff;
   logic [pre_pkg::CNT_W-1:0] lead1_ff, lead2_ff;
   logic [pre_pkg::LEAD_W-1:0] lead3_ff;
   logic [6:0]                r100_2_ff, r100_3_ff;
   logic [3:0]                r10_ff;

   // stage handshake
   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign n_in     = in_count & CNT_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // stage 1: quotient by 100 and first thousands step
   always_ff @(posedge clock) begin
      if (rdy1) begin
         n1_ff    <= n_in;
         nc1_ff   <= NOCNT_OK && (n_in == CNT_MASK);
         q100_ff  <= pre_pkg::div100(n_in);
         lead1_ff <= pre_pkg::lead_step(n_in);
      end
   end

   // stage 2: remainder by 100 and second thousands step
   always_ff @(posedge clock) begin
      if (rdy2) begin
         n2_ff     <= n1_ff;
         nc2_ff    <= nc1_ff;
         r100_2_ff <= 7'(n1_ff - pre_pkg::CNT_W'(q100_ff * pre_pkg::CNT_W'(100)));
         lead2_ff  <= pre_pkg::lead_step(lead1_ff);
      end
   end

   // stage 3: remainder by 10 and last thousands step
   always_ff @(posedge clock) begin
      if (rdy3) begin
         n3_ff     <= n2_ff;
         nc3_ff    <= nc2_ff;
         r100_3_ff <= r100_2_ff;
         r10_ff    <= pre_pkg::mod10_small(r100_2_ff);
         lead3_ff  <= pre_pkg::LEAD_W'(pre_pkg::lead_step(lead2_ff));
      end
   end

   assign out_valid     = v3_ff;
   assign out_red.n     = n3_ff;
   assign out_red.r100  = r100_3_ff;
   assign out_red.r10   = r10_ff;
   assign out_red.lead  = lead3_ff;
   assign out_red.nocnt = nc3_ff;

endmodule

>>> hdl/pre_match.sv
// pre_match: three pipeline stages that test every term, fold AND groups
// and pick the first matching rule. Uses pre_pkg.
module pre_match (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  pre_pkg::red_type           in_red,
   input  pre_pkg::prog_type          prog,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [pre_pkg::FORM_W-1:0] out_form
);

   localparam int T = pre_pkg::MAX_TERMS;

   logic                       v4_ff, v5_ff, v6_ff;
   logic                       rdy4, rdy5, rdy6;
   logic [T-1:0]               res_in, res_ff;
   logic [T-1:0]               used;
   logic [T-1:0]               gt_in, gt_ff;
   logic [T-1:0]               rule_true;
   logic                       skip4_ff, skip5_ff;
   logic [pre_pkg::FORM_W-1:0] form_in, form_ff;

   // one term against the reduced count
   function automatic logic term_match(input pre_pkg::red_type r, input logic [7:0] op,
                                       input logic [7:0] a, input logic [7:0] b);
      logic [pre_pkg::CNT_W-1:0] left;
      logic                      hit;
      if (op[pre_pkg::OP_MOD10_BIT]) left = pre_pkg::CNT_W'(r.r10);
      else if (op[pre_pkg::OP_MOD100_BIT]) left = pre_pkg::CNT_W'(r.r100);
      else if (op[pre_pkg::OP_LEAD_BIT]) left = pre_pkg::CNT_W'(r.lead);
      else left = r.n;
      unique case (op[2:0])
         pre_pkg::CMP_EQ:      hit = (left == pre_pkg::CNT_W'(a));
         pre_pkg::CMP_LT:      hit = (left < pre_pkg::CNT_W'(a));
         pre_pkg::CMP_LE:      hit = (left <= pre_pkg::CNT_W'(a));
         pre_pkg::CMP_BETWEEN: hit = (left >= pre_pkg::CNT_W'(a)) &&
                                     (left <= pre_pkg::CNT_W'(b));
         default:              hit = 1'b0;
      endcase
      return hit ^ op[pre_pkg::OP_NOT_BIT];
   endfunction

   // stage handshake
   assign rdy6     = !v6_ff || out_ready;
   assign rdy5     = !v5_ff || rdy6;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy4) v4_ff <= in_valid;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   // term results and slot use
   always_comb begin
      for (int t = 0; t < T; t++) begin
         res_in[t] = term_match(in_red, prog.op[t], prog.r1[t], prog.r2[t]);
         used[t]   = (pre_pkg::TERM_W'(t) < prog.term_count);
      end
   end

   // AND groups
   always_comb begin
      for (int g = 0; g < T; g++) begin
         gt_in[g] = 1'b1;
         for (int t = 0; t < T; t++) begin
            if (used[t] && (prog.gid[t] == pre_pkg::TERM_W'(g)) && !res_ff[t]) gt_in[g] = 1'b0;
         end
      end
   end

   // OR of groups per rule, then first matching rule
   always_comb begin
      for (int r = 0; r < T; r++) begin
         rule_true[r] = 1'b0;
         for (int t = 0; t < T; t++) begin
            if (used[t] && (prog.rid[t] == pre_pkg::TERM_W'(r)) && gt_ff[prog.gid[t]])
               rule_true[r] = 1'b1;
         end
      end
      form_in = pre_pkg::FORM_W'(prog.rule_count);
      for (int r = T - 1; r >= 0; r--) begin
         if (rule_true[r]) form_in = pre_pkg::FORM_W'(r);
      end
      if (skip5_ff) form_in = '0;
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         res_ff   <= res_in;
         skip4_ff <= in_red.nocnt || prog.empty || !prog.valid;
      end
      if (rdy5) begin
         gt_ff    <= gt_in;
         skip5_ff <= skip4_ff;
      end
      if (rdy6) form_ff <= form_in;
   end

   assign out_valid = v6_ff;
   assign out_form  = form_ff;

endmodule

>>> hdl/plural_rule_evaluator_top.sv
// Six register stages (three reduction, three match) lie between an accepted
// item and its result; one item per cycle sustained while rsp_ready is high
// and the decoder is idle. After a register write the rule decoder walks the
// program one byte per cycle, busy while it walks up to length bytes (length
// capped at RULE_BYTES and 32), and no item is taken meanwhile.
// Reset (synchronous) clears the registers, the pipeline and the decoder.
// Uses pre_pkg, pre_decoder, pre_reduce, pre_match.
module plural_rule_evaluator_top #(
   parameter int RULE_BYTES  = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pre_pkg::CNT_W-1:0]       req_count_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pre_pkg::FORM_W-1:0]      rsp_plural_form,
   output logic                            rsp_rules_valid,
   input  logic                            csr_we,
   input  logic [pre_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pre_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [pre_pkg::LEN_W-1:0]                len_ff;
   logic [3:0][pre_pkg::CSR_DATA_W-1:0]      word_ff;
   logic [pre_pkg::WORD_BYTES-1:0][7:0]      rule_bytes;
   logic                                     dec_busy;
   pre_pkg::prog_type                        prog;
   logic                                     red_in_ready;
   logic                                     red_valid, red_ready;
   pre_pkg::red_type                         red;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         word_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pre_pkg::CSR_RULE_LENGTH: len_ff     <= csr_wdata[pre_pkg::LEN_W-1:0];
            pre_pkg::CSR_RULE_WORD_0: word_ff[0] <= csr_wdata;
            pre_pkg::CSR_RULE_WORD_1: word_ff[1] <= csr_wdata;
            pre_pkg::CSR_RULE_WORD_2: word_ff[2] <= csr_wdata;
            pre_pkg::CSR_RULE_WORD_3: word_ff[3] <= csr_wdata;
            default: len_ff <= len_ff;
         endcase
      end
   end

   assign rule_bytes = word_ff;

   pre_decoder #(.RULE_BYTES(RULE_BYTES)) u_decoder (
      .clock       (clock),
      .reset       (reset),
      .start       (csr_we),
      .rule_length (len_ff),
      .rule_bytes  (rule_bytes),
      .busy        (dec_busy),
      .prog        (prog)
   );

   // no item enters while the table is being rebuilt
   assign req_ready = red_in_ready && !dec_busy;

   pre_reduce #(.COUNT_WIDTH(COUNT_WIDTH)) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid && !dec_busy),
      .in_ready  (red_in_ready),
      .in_count  (req_count_value),
      .out_valid (red_valid),
      .out_ready (red_ready),
      .out_red   (red)
   );

   pre_match u_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (red_valid),
      .in_ready  (red_ready),
      .in_red    (red),
      .prog      (prog),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_form  (rsp_plural_form)
   );

   assign rsp_rules_valid = prog.valid;

   // a write always starts a table rebuild
   a_write_starts_decode: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> dec_busy)
      else $error("register write did not start decode");

   // form never beyond the rule count
   a_form_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_plural_form <= pre_pkg::FORM_W'(prog.rule_count)))
      else $error("plural form beyond rule count");

   // a bad program always gives form zero
   a_invalid_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_rules_valid) |-> (rsp_plural_form == '0))
      else $error("invalid program gave nonzero form");

   // no item passes from reduction to match when a table rebuild starts
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      dec_busy |-> !(red_valid && red_ready && $rose(dec_busy)))
      else $error("item in flight at decode start");

endmodule

>>> test/tb_plural_rule_evaluator_top.sv
// tb_plural_rule_evaluator_top: self-checking bench for the plural rule evaluator,
// with a queue-fed driver, a monitor and a predictor of plural form and rule validity.
// Depends on pre_pkg and plural_rule_evaluator_top.
module tb_plural_rule_evaluator_top;

   localparam int CYCLE_LIMIT = 400000;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [pre_pkg::CNT_W-1:0]      req_count_value;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [pre_pkg::FORM_W-1:0]     rsp_plural_form;
   logic                           rsp_rules_valid;
   logic                           csr_we;
   logic [pre_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pre_pkg::CSR_DATA_W-1:0] csr_wdata;

   typedef struct {
      logic [pre_pkg::FORM_W-1:0] form;
      logic                       valid;
   } form_result_type;

   // predictor copy of the rule registers
   logic [5:0]        pgm_length;
   logic [63:0]       pgm_word [4];

   logic [pre_pkg::CNT_W-1:0] count_queue [$];
   form_result_type   form_queue [$];
   int                error_count;
   int                cycle_count;
   bit                idle_allowed;
   bit                hold_rsp;
   bit                req_taken;
   int                hold_cycles;
   int                send_gap;
   int                recv_gap;

   plural_rule_evaluator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_count_value(req_count_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_plural_form(rsp_plural_form),
      .rsp_rules_valid(rsp_rules_valid),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic int pgm_len();
      int n;
      n = pgm_length;
      if (n > 32) n = 32;
      return n;
   endfunction

   function automatic logic [7:0] pgm_byte(int i, int len);
      if (i >= len) return 8'h00;
      return pgm_word[i >> 3][8 * (i & 7) +: 8];
   endfunction

   function automatic bit program_ok(int len);
      int pos;
      logic [7:0] op;
      logic [7:0] c;
      pos = 0;
      if (len == 0) return 1'b1;
      forever begin
         op = pgm_byte(pos, len);
         if (op[pre_pkg::OP_LMASK_BIT]) return 1'b0;
         pos++;
         if (pos >= len) return 1'b0;
         if (op[2:0] == 3'd0) return 1'b0;
         if (op[2:0] == pre_pkg::CMP_BETWEEN) begin
            pos++;
            if (pos >= len) return 1'b0;
         end
         pos++;
         if (pos >= len) return 1'b1;
         c = pgm_byte(pos, len);
         if (c != pre_pkg::CON_AND && c != pre_pkg::CON_OR && c != pre_pkg::CON_NEW)
            return 1'b0;
         pos++;
         if (pos >= len) return 1'b0;
      end
   endfunction

   function automatic logic [pre_pkg::CNT_W-1:0] reduced_count(logic [pre_pkg::CNT_W-1:0] n,
                                                               logic [7:0] op);
      if (op[pre_pkg::OP_MOD10_BIT]) return n % 10;
      if (op[pre_pkg::OP_MOD100_BIT]) return n % 100;
      if (op[pre_pkg::OP_LEAD_BIT]) while (n >= 1000) n = n / 1000;
      return n;
   endfunction

   function automatic int matching_form(logic [pre_pkg::CNT_W-1:0] n, int len);
      int pos;
      int form;
      bit any_term;
      bit all_terms;
      bit hit;
      logic [7:0] op;
      logic [pre_pkg::CNT_W-1:0] lhs;
      logic [7:0] r1;
      logic [7:0] r2;
      pos = 0;
      form = 0;
      forever begin
         any_term = 1'b0;
         forever begin
            all_terms = 1'b1;
            forever begin
               op = pgm_byte(pos, len);
               pos++;
               lhs = reduced_count(n, op);
               r1 = pgm_byte(pos, len);
               pos++;
               r2 = 8'h00;
               if (op[2:0] == pre_pkg::CMP_BETWEEN) begin
                  r2 = pgm_byte(pos, len);
                  pos++;
               end
               hit = (op[2:0] == pre_pkg::CMP_EQ && lhs == r1) ||
                     (op[2:0] == pre_pkg::CMP_LT && lhs < r1) ||
                     (op[2:0] == pre_pkg::CMP_LE && lhs <= r1) ||
                     (op[2:0] == pre_pkg::CMP_BETWEEN && lhs >= r1 && lhs <= r2);
               if (op[pre_pkg::OP_NOT_BIT]) hit = !hit;
               all_terms = all_terms && hit;
               if (pos >= len || pgm_byte(pos, len) != pre_pkg::CON_AND) break;
               pos++;
            end
            any_term = any_term || all_terms;
            if (pos >= len || pgm_byte(pos, len) != pre_pkg::CON_OR) break;
            pos++;
         end
         if (any_term) return form;
         form++;
         if (pos >= len) return form;
         pos++;
      end
   endfunction

   function automatic form_result_type predict_form(logic [pre_pkg::CNT_W-1:0] n);
      form_result_type r;
      int len;
      len = pgm_len();
      r.valid = program_ok(len);
      r.form = '0;
      if (len != 0 && r.valid && n != '1) r.form = pre_pkg::FORM_W'(matching_form(n, len));
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // append one count to the pending items
   task automatic add_count(logic [pre_pkg::CNT_W-1:0] n);
      count_queue = {count_queue, n};
   endtask

   // rule register write, block idle
   task automatic write_reg(pre_pkg::csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == pre_pkg::CSR_RULE_LENGTH) pgm_length = value[5:0];
      else pgm_word[idx - 1] = value;
   endtask

   task automatic load_program(logic [7:0] bytes [$], int len);
      logic [63:0] w;
      for (int k = 0; k < 4; k++) begin
         w = '0;
         for (int b = 0; b < 8; b++)
            if (8 * k + b < bytes.size()) w[8 * b +: 8] = bytes[8 * k + b];
         write_reg(pre_pkg::csr_index_type'(pre_pkg::CSR_RULE_WORD_0 + k), w);
      end
      write_reg(pre_pkg::CSR_RULE_LENGTH, 64'(len));
   endtask

   task automatic wait_drained();
      while (count_queue.size() != 0 || form_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [pre_pkg::CNT_W-1:0] random_count();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 30);
         1: return $urandom_range(0, 250);
         2: return $urandom_range(990, 250000);
         3: return '1 - $urandom_range(0, 2);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] random_opcode();
      logic [7:0] op;
      op = $urandom;
      op[7] = 1'b0;
      if ($urandom_range(0, 9) != 0) op[2:0] = 3'($urandom_range(1, 4));
      return op;
   endfunction

   // well-formed program, occasionally broken
   task automatic random_program(int items);
      logic [7:0] bytes [$];
      logic [7:0] op;
      int terms;
      int len;
      terms = $urandom_range(1, 7);
      for (int t = 0; t < terms; t++) begin
         op = random_opcode();
         if (bytes.size() + 5 > 32) break;
         if (t != 0) begin
            case ($urandom_range(0, 2))
               0: bytes = {bytes, pre_pkg::CON_AND};
               1: bytes = {bytes, pre_pkg::CON_OR};
               default: bytes = {bytes, pre_pkg::CON_NEW};
            endcase
         end
         bytes = {bytes, op};
         bytes = {bytes, 8'(op[pre_pkg::OP_LEAD_BIT] ? $urandom_range(0, 255) :
                                                       $urandom_range(0, 20))};
         if (op[2:0] == pre_pkg::CMP_BETWEEN) bytes = {bytes, 8'($urandom_range(0, 120))};
      end
      len = bytes.size();
      case ($urandom_range(0, 9))
         0: begin
            bytes[$urandom_range(0, len - 1)] = 8'($urandom);
         end
         1: len = $urandom_range(0, 63);
         default: ;
      endcase
      while (bytes.size() < 32) bytes = {bytes, 8'($urandom)};
      if (len < 32) for (int i = len; i < 32; i++) bytes[i] = 8'($urandom);
      load_program(bytes, len);
      for (int i = 0; i < items; i++) add_count(random_count());
      wait_drained();
   endtask

   // acceptance seen at the clock edge
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the offered item
      end else begin
         if (req_valid) void'(count_queue.pop_front());
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (count_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_count_value <= count_queue[0];
            if (idle_allowed && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 5);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predictions on acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         form_queue = {form_queue, predict_form(req_count_value)};
   end

   // monitor
   always @(posedge clock) begin
      form_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (form_queue.size() == 0) begin
            report_mismatch("unexpected item", rsp_plural_form, -1);
         end else begin
            want = form_queue.pop_front();
            if (rsp_plural_form !== want.form)
               report_mismatch("plural_form", rsp_plural_form, want.form);
            if (rsp_rules_valid !== want.valid)
               report_mismatch("rules_valid", rsp_rules_valid, want.valid);
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_allowed && $urandom_range(0, 6) == 0) recv_gap <= $urandom_range(1, 5);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [7:0] prog [$];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = pre_pkg::CSR_RULE_LENGTH;
      csr_wdata = '0;
      error_count = 0;
      idle_allowed = 1'b1;
      hold_rsp = 1'b0;
      pgm_length = '0;
      for (int k = 0; k < 4; k++) pgm_word[k] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty program, extremes of the count
      add_count('0);
      add_count('1);
      add_count(32'h5555_AAAA);
      wait_drained();

      // three-rule set: n%10==1 and n%100!=11, then n%10 in 2..4 or lead < 5, then the rest
      prog = '{8'h11, 8'd1, pre_pkg::CON_AND, 8'h29, 8'd11, pre_pkg::CON_NEW, 8'h14, 8'd2,
               8'd4, pre_pkg::CON_OR, 8'h42, 8'd5, pre_pkg::CON_NEW, 8'h03, 8'd0,
               pre_pkg::CON_OR, 8'h37, 8'd9};
      load_program(prog, prog.size());
      foreach (prog[i]) if (i < 12) add_count(pre_pkg::CNT_W'(i * 10 + 1));
      add_count(32'd111);
      add_count(32'd4_000_000);
      add_count('1);
      add_count(32'hFFFF_FFFE);
      wait_drained();

      // invalid: opcode with top bit, then program ending on a connector
      prog = '{8'h81, 8'd1};
      load_program(prog, 2);
      add_count(32'd1);
      wait_drained();
      prog = '{8'h01, 8'd1, pre_pkg::CON_AND};
      load_program(prog, 3);
      add_count(32'd1);
      wait_drained();
      // oversized length saturates
      write_reg(pre_pkg::CSR_RULE_LENGTH, 64'd63);
      write_reg(pre_pkg::CSR_RULE_WORD_0, '1);
      write_reg(pre_pkg::CSR_RULE_WORD_1, '0);
      add_count(32'd7);
      wait_drained();

      // long receiver hold-off while items keep coming
      random_program(0);
      hold_rsp = 1'b1;
      for (int i = 0; i < 40; i++) add_count(random_count());
      while (hold_cycles < 200) @(posedge clock);
      hold_rsp = 1'b0;
      wait_drained();

      // random programs with random counts
      for (int p = 0; p < 60; p++) begin
         if (p == 50) idle_allowed = 1'b0;
         random_program($urandom_range(8, 18));
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
